// ===== hdl/hvta_pkg.sv =====
// Shared constants and types for the host to video memory transfer address generator.
package hvta_pkg;

  // Default geometry of the coordinate space and of the video memory address.
  localparam int COORD_WRAP_DEF     = 2048;
  localparam int VRAM_ADDR_BITS_DEF = 20;

  // Field widths.
  localparam int DATA_W      = 64;
  localparam int PIXEL_W     = 32;
  localparam int WADDR_W     = 20;
  localparam int BASE_W      = 14;
  localparam int ROW_W       = 6;
  localparam int ORIGIN_W    = 11;
  localparam int AREA_W      = 12;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  // Log2 of the number of words in one base or row unit.
  localparam int UNIT_SHIFT = 6;

  // Command codes carried on the input tuser.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  // Configuration register indexes (byte address divided by four).
  typedef enum logic [2:0] {
    REG_DEST_BASE      = 3'd0,
    REG_DEST_ROW_WIDTH = 3'd1,
    REG_RECT_ORIGIN_X  = 3'd2,
    REG_RECT_ORIGIN_Y  = 3'd3,
    REG_AREA_WIDTH     = 3'd4,
    REG_AREA_HEIGHT    = 3'd5
  } reg_idx_t;

endpackage

// ===== hdl/host_to_vram_transfer_addressing.sv =====
// Top level of the host to video memory rectangular transfer address generator.
//
// Usage: program the destination base, row width, rectangle origin and size
// over the APB port while the block is idle. On the slave stream, tuser = 0
// starts a transfer at the rectangle origin (tdata ignored, no result) and
// tuser = 1 carries a 64-bit word of two 32-bit pixels. Each word of an active
// transfer gives two pixel writes on the master stream, low half first; the
// final write of a word carries tlast. A word that ends the rectangle on its
// low half gives only that write. A word outside a transfer gives one result
// with the reject flag set.
// A word is accepted into the input register and its result is presented from the output register.
// Throughput: the master side carries one write per cycle, unless stalled, into a single
// memory port, so a word with two writes holds the input register for both, while a word with
// one write, or a start command, frees it on its first step.
// The input register frees in the cycle its last write moves to the output
// register, so a new word is accepted while the previous result waits.
// Reset clears the cursor, the busy flag, the configuration registers and
// both stream stages. A stalled master side holds its result and, once the
// input register holds a data word, holds the slave side off through tready.
module host_to_vram_transfer_addressing #(
  parameter int COORD_WRAP          = hvta_pkg::COORD_WRAP_DEF,
  parameter int VRAM_WORD_ADDR_BITS = hvta_pkg::VRAM_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hvta_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [hvta_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [hvta_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [hvta_pkg::DATA_W-1:0]         s_tdata,   // data_word
  input  logic                                s_tuser,   // command
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [hvta_pkg::OUT_TDATA_W-1:0]    m_tdata,   // write_address, pixel_value, zeros
  output logic [1:0]                          m_tuser,   // status, transfer_done
  output logic                                m_tlast
);

  // Cursor width covers the wrap point and the farthest rectangle edge.
  localparam int EDGE_W  = hvta_pkg::ORIGIN_W + 2;
  localparam int WRAP_W  = $clog2(COORD_WRAP + 1);
  localparam int CUR_W   = (WRAP_W > EDGE_W) ? WRAP_W : EDGE_W;
  localparam int PROD_W  = CUR_W + hvta_pkg::ROW_W;
  localparam int SUM_W   = PROD_W + hvta_pkg::UNIT_SHIFT + 2;
  localparam int MASK_W  = (VRAM_WORD_ADDR_BITS < SUM_W) ? VRAM_WORD_ADDR_BITS : SUM_W;
  localparam logic [CUR_W-1:0] WRAP_VAL = CUR_W'(COORD_WRAP);
  localparam logic [SUM_W-1:0] ADDR_MASK = SUM_W'((64'(1) << MASK_W) - 64'(1));

  // Configuration registers
  logic [hvta_pkg::BASE_W-1:0]   dest_base;
  logic [hvta_pkg::ROW_W-1:0]    dest_row_width;
  logic [hvta_pkg::ORIGIN_W-1:0] rect_origin_x;
  logic [hvta_pkg::ORIGIN_W-1:0] rect_origin_y;
  logic [hvta_pkg::AREA_W-1:0]   area_width;
  logic [hvta_pkg::AREA_W-1:0]   area_height;

  // Cursor state
  logic [CUR_W-1:0] cursor_x, cursor_x_next;
  logic [CUR_W-1:0] cursor_y, cursor_y_next;
  logic             busy, busy_next;

  // Input register
  logic                        hold_valid;
  logic                        hold_cmd;
  logic [hvta_pkg::DATA_W-1:0] hold_data;
  logic                        hold_half;

  // Step signals
  logic                          out_free;
  logic                          step_en;
  logic                          item_finish;
  logic                          is_start;
  logic                          step_done;
  logic [CUR_W-1:0]              x_inc, y_inc, end_x, end_y;
  logic [PROD_W-1:0]             row_prod;
  logic [SUM_W-1:0]              addr_sum;
  logic [hvta_pkg::WADDR_W-1:0]  res_addr;
  logic [hvta_pkg::PIXEL_W-1:0]  res_pixel;
  logic                          res_status;
  logic                          res_last;
  logic [2:0]                    cfg_idx;
  logic                          cfg_write;

  // APB decode and read-back
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      hvta_pkg::REG_DEST_BASE:      prdata = hvta_pkg::CFG_DATA_W'(dest_base);
      hvta_pkg::REG_DEST_ROW_WIDTH: prdata = hvta_pkg::CFG_DATA_W'(dest_row_width);
      hvta_pkg::REG_RECT_ORIGIN_X:  prdata = hvta_pkg::CFG_DATA_W'(rect_origin_x);
      hvta_pkg::REG_RECT_ORIGIN_Y:  prdata = hvta_pkg::CFG_DATA_W'(rect_origin_y);
      hvta_pkg::REG_AREA_WIDTH:     prdata = hvta_pkg::CFG_DATA_W'(area_width);
      hvta_pkg::REG_AREA_HEIGHT:    prdata = hvta_pkg::CFG_DATA_W'(area_height);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_base      <= '0;
      dest_row_width <= '0;
      rect_origin_x  <= '0;
      rect_origin_y  <= '0;
      area_width     <= '0;
      area_height    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        hvta_pkg::REG_DEST_BASE:      dest_base      <= pwdata[hvta_pkg::BASE_W-1:0];
        hvta_pkg::REG_DEST_ROW_WIDTH: dest_row_width <= pwdata[hvta_pkg::ROW_W-1:0];
        hvta_pkg::REG_RECT_ORIGIN_X:  rect_origin_x  <= pwdata[hvta_pkg::ORIGIN_W-1:0];
        hvta_pkg::REG_RECT_ORIGIN_Y:  rect_origin_y  <= pwdata[hvta_pkg::ORIGIN_W-1:0];
        hvta_pkg::REG_AREA_WIDTH:     area_width     <= pwdata[hvta_pkg::AREA_W-1:0];
        hvta_pkg::REG_AREA_HEIGHT:    area_height    <= pwdata[hvta_pkg::AREA_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control: a start needs no output slot, a write needs a free one.
  assign out_free    = !m_tvalid || m_tready;
  assign is_start    = (hold_cmd == hvta_pkg::CMD_START);
  assign step_en     = hold_valid && (is_start || out_free);
  assign item_finish = step_en && (is_start || !busy || hold_half || step_done);
  assign s_tready    = !hold_valid || item_finish;

  // Address of the current cursor position, wrapped to the memory size.
  assign row_prod = PROD_W'(cursor_y) * PROD_W'(dest_row_width);
  assign addr_sum = (SUM_W'(dest_base) << hvta_pkg::UNIT_SHIFT)
                  + (SUM_W'(row_prod) << hvta_pkg::UNIT_SHIFT)
                  + SUM_W'(cursor_x);

  // Cursor advance for one pixel.
  assign x_inc = cursor_x + CUR_W'(1);
  assign y_inc = cursor_y + CUR_W'(1);
  assign end_x = CUR_W'(rect_origin_x) + CUR_W'(area_width);
  assign end_y = CUR_W'(rect_origin_y) + CUR_W'(area_height);

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    busy_next     = busy;
    step_done     = 1'b0;
    if (is_start) begin
      cursor_x_next = CUR_W'(rect_origin_x);
      cursor_y_next = CUR_W'(rect_origin_y);
      busy_next     = 1'b1;
    end else if (busy) begin
      if (x_inc == WRAP_VAL) begin
        cursor_x_next = '0;
      end else if (x_inc >= end_x) begin
        cursor_x_next = CUR_W'(rect_origin_x);
        if (y_inc == WRAP_VAL) begin
          cursor_y_next = '0;
        end else if (y_inc >= end_y) begin
          cursor_y_next = y_inc;
          busy_next     = 1'b0;
          step_done     = 1'b1;
        end else begin
          cursor_y_next = y_inc;
        end
      end else begin
        cursor_x_next = x_inc;
      end
    end
  end

  // Result fields for the current half, or a reject when no transfer runs.
  always_comb begin
    if (busy) begin
      res_addr   = hvta_pkg::WADDR_W'(addr_sum & ADDR_MASK);
      res_pixel  = hold_half ? hold_data[2*hvta_pkg::PIXEL_W-1:hvta_pkg::PIXEL_W]
                             : hold_data[hvta_pkg::PIXEL_W-1:0];
      res_status = 1'b0;
      res_last   = hold_half || step_done;
    end else begin
      res_addr   = '0;
      res_pixel  = '0;
      res_status = 1'b1;
      res_last   = 1'b1;
    end
  end

  // Input register and cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_half  <= 1'b0;
      cursor_x   <= '0;
      cursor_y   <= '0;
      busy       <= 1'b0;
    end else begin
      if (step_en) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
        busy     <= busy_next;
      end
      if (s_tvalid && s_tready) begin
        hold_valid <= 1'b1;
        hold_half  <= 1'b0;
      end else if (item_finish) begin
        hold_valid <= 1'b0;
        hold_half  <= 1'b0;
      end else if (step_en) begin
        hold_half  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_cmd  <= s_tuser;
      hold_data <= s_tdata;
    end
  end

  // Output register: loaded with one write per data step, held while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_en && !is_start) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && !is_start) begin
      m_tdata <= {(hvta_pkg::OUT_TDATA_W - hvta_pkg::PIXEL_W - hvta_pkg::WADDR_W)'(0),
                  res_pixel, res_addr};
      m_tuser <= {step_done, res_status};
      m_tlast <= res_last;
    end
  end

endmodule

// ===== bench/host_to_vram_transfer_addressing_tb.sv =====
// Self-checking testbench for the host to video memory rectangular transfer address generator.
module host_to_vram_transfer_addressing_tb;

  localparam int COORD_WRAP = hvta_pkg::COORD_WRAP_DEF;

  // One pixel write as seen on the master stream.
  typedef struct packed {
    logic [hvta_pkg::WADDR_W-1:0] waddr;
    logic [hvta_pkg::PIXEL_W-1:0] pixel;
    logic                         reject;
    logic                         done;
    logic                         last;
  } pix_write_t;

  // Kinds of rows in the directed stimulus table.
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_CHECKED
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    hvta_pkg::reg_idx_t idx;
    hvta_pkg::cmd_t     cmd;
    logic [63:0]        value;
    pix_write_t         want;
  } stim_row_t;

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [hvta_pkg::CFG_ADDR_W-1:0]  paddr;
  logic [hvta_pkg::CFG_DATA_W-1:0]  pwdata;
  logic [hvta_pkg::CFG_DATA_W-1:0]  prdata;
  logic                             pready;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [hvta_pkg::DATA_W-1:0]      s_tdata;   // data_word
  logic                             s_tuser;   // command
  logic                             m_tvalid;
  logic                             m_tready;
  logic [hvta_pkg::OUT_TDATA_W-1:0] m_tdata;   // write_address, pixel_value, zeros
  logic [1:0]                       m_tuser;   // status, transfer_done
  logic                             m_tlast;

  // Shadow copy of the geometry registers.
  logic [hvta_pkg::BASE_W-1:0]   cfg_base;
  logic [hvta_pkg::ROW_W-1:0]    cfg_row_units;
  logic [hvta_pkg::ORIGIN_W-1:0] cfg_org_x;
  logic [hvta_pkg::ORIGIN_W-1:0] cfg_org_y;
  logic [hvta_pkg::AREA_W-1:0]   cfg_span_w;
  logic [hvta_pkg::AREA_W-1:0]   cfg_span_h;

  // Predicted cursor and transfer state.
  int unsigned cur_x;
  int unsigned cur_y;
  bit          xfer_busy;

  pix_write_t  expected_writes[$];
  pix_write_t  next_writes[2];
  stim_row_t   stim_table[$];
  int          fail_count;
  int          send_gap_pct;
  int          stall_pct;

  host_to_vram_transfer_addressing u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Word address of the pixel under the cursor.
  function automatic logic [hvta_pkg::WADDR_W-1:0] cursor_addr();
    logic [63:0] sum;
    sum = 64'(cfg_base) * 64 + 64'(cur_y) * 64'(cfg_row_units) * 64 + 64'(cur_x);
    return sum[hvta_pkg::WADDR_W-1:0];
  endfunction

  // Step the cursor one pixel; returns 1 when the rectangle is complete.
  function automatic bit advance_cursor();
    cur_x = cur_x + 1;
    if (cur_x == COORD_WRAP) begin
      cur_x = 0;
    end else if (cur_x >= int'(cfg_org_x) + int'(cfg_span_w)) begin
      cur_x = 32'(cfg_org_x);
      cur_y = cur_y + 1;
      if (cur_y == COORD_WRAP) begin
        cur_y = 0;
      end else if (cur_y >= int'(cfg_org_y) + int'(cfg_span_h)) begin
        xfer_busy = 1'b0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Work out the pixel writes caused by one accepted item.
  function automatic int predict_writes(hvta_pkg::cmd_t cmd, logic [63:0] word);
    logic [hvta_pkg::WADDR_W-1:0] addr;
    bit                           fin;
    if (cmd == hvta_pkg::CMD_START) begin
      cur_x     = 32'(cfg_org_x);
      cur_y     = 32'(cfg_org_y);
      xfer_busy = 1'b1;
      return 0;
    end
    if (!xfer_busy) begin
      next_writes[0] = '{waddr: '0, pixel: '0, reject: 1'b1, done: 1'b0, last: 1'b1};
      return 1;
    end
    addr = cursor_addr();
    fin  = advance_cursor();
    next_writes[0] = '{waddr: addr, pixel: word[31:0], reject: 1'b0, done: fin, last: fin};
    if (fin) begin
      return 1;
    end
    addr = cursor_addr();
    fin  = advance_cursor();
    next_writes[1] = '{waddr: addr, pixel: word[63:32], reject: 1'b0, done: fin, last: 1'b1};
    return 2;
  endfunction

  // Register write over the configuration port, mirrored into the shadow copy.
  task automatic apb_write(hvta_pkg::reg_idx_t idx, logic [hvta_pkg::CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // An idle period between accesses keeps the bus signals to one change per edge.
    @(negedge clk);
    case (idx)
      hvta_pkg::REG_DEST_BASE:      cfg_base      = val[hvta_pkg::BASE_W-1:0];
      hvta_pkg::REG_DEST_ROW_WIDTH: cfg_row_units = val[hvta_pkg::ROW_W-1:0];
      hvta_pkg::REG_RECT_ORIGIN_X:  cfg_org_x     = val[hvta_pkg::ORIGIN_W-1:0];
      hvta_pkg::REG_RECT_ORIGIN_Y:  cfg_org_y     = val[hvta_pkg::ORIGIN_W-1:0];
      hvta_pkg::REG_AREA_WIDTH:     cfg_span_w    = val[hvta_pkg::AREA_W-1:0];
      hvta_pkg::REG_AREA_HEIGHT:    cfg_span_h    = val[hvta_pkg::AREA_W-1:0];
      default: ;
    endcase
  endtask

  // Present one item on the slave stream and record what it should produce.
  task automatic send_item(hvta_pkg::cmd_t cmd, logic [63:0] word, bit use_fixed,
                           pix_write_t fixed);
    int n;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    n = predict_writes(cmd, word);
    if (use_fixed) begin
      expected_writes.push_back(fixed);
    end else begin
      for (int i = 0; i < n; i++) expected_writes.push_back(next_writes[i]);
    end
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted write has come out.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(negedge clk);
    // A start command may still be in flight with nothing to show for it.
    repeat (4) @(negedge clk);
  endtask

  // Directed table helpers.
  task automatic add_cfg(hvta_pkg::reg_idx_t idx, logic [31:0] val);
    stim_table.push_back('{kind: ROW_CFG, idx: idx, cmd: hvta_pkg::CMD_START,
                           value: 64'(val), want: '0});
  endtask

  task automatic add_item(hvta_pkg::cmd_t cmd, logic [63:0] word);
    stim_table.push_back('{kind: ROW_ITEM, idx: hvta_pkg::REG_DEST_BASE, cmd: cmd,
                           value: word, want: '0});
  endtask

  task automatic add_checked(hvta_pkg::cmd_t cmd, logic [63:0] word, pix_write_t want);
    stim_table.push_back('{kind: ROW_CHECKED, idx: hvta_pkg::REG_DEST_BASE, cmd: cmd,
                           value: word, want: want});
  endtask

  // Pick a new destination geometry: mostly small rectangles, sometimes extremes.
  task automatic pick_geometry();
    int kind;
    kind = $urandom_range(0, 9);
    settle();
    if (kind == 0) begin
      apb_write(hvta_pkg::REG_DEST_BASE,      $urandom_range(0, 1) ? 32'd16383 : 32'd0);
      apb_write(hvta_pkg::REG_DEST_ROW_WIDTH, $urandom_range(0, 1) ? 32'd63 : 32'd0);
      apb_write(hvta_pkg::REG_RECT_ORIGIN_X,  $urandom_range(0, 1) ? 32'd2047 : 32'd0);
      apb_write(hvta_pkg::REG_RECT_ORIGIN_Y,  $urandom_range(0, 1) ? 32'd2047 : 32'd0);
      apb_write(hvta_pkg::REG_AREA_WIDTH,     $urandom_range(0, 1) ? 32'd4095 : 32'd0);
      apb_write(hvta_pkg::REG_AREA_HEIGHT,    $urandom_range(0, 1) ? 32'd4095 : 32'd0);
    end else begin
      apb_write(hvta_pkg::REG_DEST_BASE,      $urandom_range(0, 16383));
      apb_write(hvta_pkg::REG_DEST_ROW_WIDTH, $urandom_range(0, 63));
      apb_write(hvta_pkg::REG_RECT_ORIGIN_X,  $urandom_range(0, 2047));
      apb_write(hvta_pkg::REG_RECT_ORIGIN_Y,  $urandom_range(0, 2047));
      apb_write(hvta_pkg::REG_AREA_WIDTH,
                (kind == 1) ? $urandom_range(0, 40) : $urandom_range(0, 6));
      apb_write(hvta_pkg::REG_AREA_HEIGHT,
                (kind == 1) ? $urandom_range(0, 10) : $urandom_range(0, 4));
    end
  endtask

  // Result receiver: random backpressure changes on the falling edge.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker: compare each accepted write with the oldest prediction.
  always @(posedge clk) begin
    pix_write_t got;
    pix_write_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[hvta_pkg::WADDR_W-1:0],
             m_tdata[hvta_pkg::WADDR_W+hvta_pkg::PIXEL_W-1:hvta_pkg::WADDR_W],
             m_tuser[0], m_tuser[1], m_tlast};
      if (expected_writes.size() == 0) begin
        fail_count++;
        $display("%0t: expected none, actual addr %h pix %h st %b done %b last %b",
                 $time, got.waddr, got.pixel, got.reject, got.done, got.last);
      end else begin
        want = expected_writes.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: expected %h %h %b %b %b, actual %h %h %b %b %b",
                   $time, want.waddr, want.pixel, want.reject, want.done, want.last,
                   got.waddr, got.pixel, got.reject, got.done, got.last);
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    int phase_gap[4];
    int phase_stall[4];
    int seg_items;
    int burst;
    int r;
    int wait_cycles;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = hvta_pkg::CMD_START;
    fail_count   = 0;
    send_gap_pct = 0;
    stall_pct    = 0;
    cfg_base      = '0;
    cfg_row_units = '0;
    cfg_org_x     = '0;
    cfg_org_y     = '0;
    cfg_span_w    = '0;
    cfg_span_h    = '0;
    cur_x         = 0;
    cur_y         = 0;
    xfer_busy     = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: idle rejects, reset geometry, extremes, row and rectangle ends.
    add_checked(hvta_pkg::CMD_DATA, 64'h0, '{'0, '0, 1'b1, 1'b0, 1'b1});
    add_checked(hvta_pkg::CMD_DATA, '1, '{'0, '0, 1'b1, 1'b0, 1'b1});
    add_item(hvta_pkg::CMD_START, '1);
    // Reset geometry: the first pixel ends the rectangle and the high half is dropped.
    add_checked(hvta_pkg::CMD_DATA, '1, '{'0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1});
    add_checked(hvta_pkg::CMD_DATA, 64'h0123_4567_89AB_CDEF, '{'0, '0, 1'b1, 1'b0, 1'b1});
    add_cfg(hvta_pkg::REG_DEST_BASE, 32'd16383);
    add_cfg(hvta_pkg::REG_DEST_ROW_WIDTH, 32'd63);
    add_cfg(hvta_pkg::REG_RECT_ORIGIN_X, 32'd2047);
    add_cfg(hvta_pkg::REG_RECT_ORIGIN_Y, 32'd2047);
    add_cfg(hvta_pkg::REG_AREA_WIDTH, 32'd4095);
    add_cfg(hvta_pkg::REG_AREA_HEIGHT, 32'd4095);
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'hAAAA_AAAA_AAAA_AAAA);
    add_item(hvta_pkg::CMD_DATA, 64'h5555_5555_5555_5555);
    add_cfg(hvta_pkg::REG_DEST_BASE, 32'd5);
    add_cfg(hvta_pkg::REG_DEST_ROW_WIDTH, 32'd1);
    add_cfg(hvta_pkg::REG_RECT_ORIGIN_X, 32'd10);
    add_cfg(hvta_pkg::REG_RECT_ORIGIN_Y, 32'd3);
    add_cfg(hvta_pkg::REG_AREA_WIDTH, 32'd3);
    add_cfg(hvta_pkg::REG_AREA_HEIGHT, 32'd2);
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'h1111_1111_0000_0000);
    add_item(hvta_pkg::CMD_DATA, 64'h3333_3333_2222_2222);
    add_item(hvta_pkg::CMD_DATA, 64'h5555_5555_4444_4444);
    add_item(hvta_pkg::CMD_DATA, 64'h7777_7777_6666_6666);
    // One row of three pixels: the second word ends the rectangle on its low half.
    add_cfg(hvta_pkg::REG_AREA_HEIGHT, 32'd1);
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'hFFFF_0000_0000_FFFF);
    add_item(hvta_pkg::CMD_DATA, 64'h0F0F_0F0F_F0F0_F0F0);
    // A start while busy restarts at the origin.
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'hDEAD_BEEF_CAFE_F00D);
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'h8000_0001_8000_0001);
    // Zero width steps a row on every pixel.
    add_cfg(hvta_pkg::REG_AREA_WIDTH, 32'd0);
    add_cfg(hvta_pkg::REG_AREA_HEIGHT, 32'd2);
    add_cfg(hvta_pkg::REG_RECT_ORIGIN_Y, 32'd100);
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'h1234_5678_9ABC_DEF0);
    add_item(hvta_pkg::CMD_DATA, 64'h0FED_CBA9_8765_4321);
    // Zero height ends the transfer at the end of the first row.
    add_cfg(hvta_pkg::REG_AREA_WIDTH, 32'd2);
    add_cfg(hvta_pkg::REG_AREA_HEIGHT, 32'd0);
    add_item(hvta_pkg::CMD_START, 64'h0);
    add_item(hvta_pkg::CMD_DATA, 64'h7FFF_FFFF_FFFF_FFFE);

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_CFG: begin
          settle();
          apb_write(stim_table[i].idx, stim_table[i].value[31:0]);
        end
        ROW_ITEM:    send_item(stim_table[i].cmd, stim_table[i].value, 1'b0, '0);
        ROW_CHECKED: send_item(stim_table[i].cmd, stim_table[i].value, 1'b1,
                               stim_table[i].want);
        default: ;
      endcase
    end

    // Random part: four idling phases, each with several geometries.
    phase_gap   = '{0, 59, 0, 13};
    phase_stall = '{0, 0, 59, 13};
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = phase_gap[p];
      stall_pct    = phase_stall[p];
      for (int g = 0; g < 5; g++) begin
        pick_geometry();
        seg_items = 0;
        while (seg_items < 65) begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            // Let the pipeline run dry before carrying on.
            settle();
          end else if (r < 12) begin
            send_item(hvta_pkg::CMD_DATA, {$urandom, $urandom}, 1'b0, '0);
            seg_items++;
          end else if (r < 16) begin
            send_item(hvta_pkg::CMD_START, {$urandom, $urandom}, 1'b0, '0);
            seg_items++;
          end else begin
            // Well-formed transfer: a start followed by a burst of data words.
            burst = $urandom_range(1, 12);
            send_item(hvta_pkg::CMD_START, {$urandom, $urandom}, 1'b0, '0);
            for (int k = 0; k < burst; k++)
              send_item(hvta_pkg::CMD_DATA, {$urandom, $urandom}, 1'b0, '0);
            seg_items += burst + 1;
          end
        end
      end
    end

    // Drain the remaining writes, then keep watching for stray writes.
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_writes.size() != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (expected_writes.size() != 0)
      $display("%0t: %0d predicted writes never arrived", $time, expected_writes.size());

    if (fail_count == 0 && expected_writes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== host_to_vram_transfer_addressing.f =====
hdl/hvta_pkg.sv
hdl/host_to_vram_transfer_addressing.sv
bench/host_to_vram_transfer_addressing_tb.sv
